// File: hdl/dos_pkg.sv
package dos_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [15:0]        item_handle;
    logic signed [31:0] depth_key;
    logic               has_key;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        out_handle;
    logic signed [31:0] out_key;
    logic               out_has_key;
    logic               out_last;
  } out_item_t;

  // One stored entry: handle, key and key-present flag, 49 bits.
  typedef struct packed {
    logic [15:0]        handle;
    logic signed [31:0] key;
    logic               keyed;
  } entry_t;

endpackage

// File: hdl/dos_store.sv
module dos_store (
  input  logic            clk,
  input  logic            we,
  input  dos_pkg::idx_t   waddr,
  input  dos_pkg::entry_t wdata,
  input  dos_pkg::idx_t   raddr,
  output dos_pkg::entry_t rdata
);
  import dos_pkg::*;

  entry_t mem [MAX_ITEMS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/dos_cmp.sv
module dos_cmp (
  input  dos_pkg::entry_t a,
  input  dos_pkg::entry_t b,
  output logic            less
);
  import dos_pkg::*;

  // Entries without a key never take part in a comparison.
  assign less = a.keyed && b.keyed && (a.key < b.key);

endmodule

// File: hdl/depth_order_exchange_sorter.sv
// Collects up to MAX_ITEMS entries, one per accepted item, each written to a single-port-write
// entry memory. The item marked last closes the set (an item arriving while the store is full
// is dropped, though its last mark still counts) and starts an in-place exchange sort of the
// n stored entries: for each outer position x the entry is held in a register and one shared
// signed comparator walks the inner position y over all n entries, one per cycle, swapping
// through the memory's write port. Unkeyed positions are skipped and stay put. The sort time
// is set by the single comparator and memory port. Results then leave in position order,
// each read, registered and held until taken before the next is read, the final one marked
// with out_last; no item is taken from the end of the set until the last result has been
// delivered.
module depth_order_exchange_sorter (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  dos_pkg::in_item_t   item,
  output logic                result_valid,
  input  logic                result_ready,
  output dos_pkg::out_item_t  result
);
  import dos_pkg::*;

  typedef enum logic [7:0] {
    S_LOAD  = 8'b0000_0001,
    S_XRD   = 8'b0000_0010,
    S_XLD   = 8'b0000_0100,
    S_INNER = 8'b0000_1000,
    S_XWB   = 8'b0001_0000,
    S_ERD   = 8'b0010_0000,
    S_ELD   = 8'b0100_0000,
    S_EOUT  = 8'b1000_0000
  } state_t;

  state_t state;
  cnt_t   count;
  cnt_t   count_m1;
  idx_t   last_idx;
  idx_t   x;
  idx_t   y;
  entry_t cur;

  logic   we;
  idx_t   waddr;
  entry_t wdata;
  idx_t   raddr;
  entry_t rdata;
  logic   less;
  logic   swap;
  logic   x_last;
  logic   y_last;
  logic   has_room;

  dos_store u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  dos_cmp u_cmp (
    .a    (cur),
    .b    (rdata),
    .less (less)
  );

  assign item_ready = (state == S_LOAD);
  assign has_room   = (count < cnt_t'(MAX_ITEMS));
  assign count_m1   = count - 1'b1;
  assign last_idx   = count_m1[IDX_W-1:0];
  assign x_last     = (x == last_idx);
  assign y_last     = (y == last_idx);
  // The memory copy of position x is stale while x is held in cur, and an entry never swaps
  // with itself, so the inner step at y equal to x is skipped.
  assign swap       = less && (y != x);

  always_comb begin
    we    = 1'b0;
    waddr = x;
    wdata = cur;
    raddr = x;
    unique case (state)
      S_LOAD: begin
        we    = item_valid && has_room;
        waddr = count[IDX_W-1:0];
        wdata = '{handle: item.item_handle, key: item.depth_key, keyed: item.has_key};
      end
      S_XLD: begin
        raddr = '0;
      end
      S_INNER: begin
        we    = swap;
        waddr = y;
        raddr = y + 1'b1;
      end
      S_XWB: begin
        we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (item_valid) begin
            if (has_room) begin
              count <= count + 1'b1;
            end
            if (item.last) begin
              x     <= '0;
              state <= S_XRD;
            end
          end
        end
        S_XRD: begin
          state <= S_XLD;
        end
        S_XLD: begin
          cur <= rdata;
          if (rdata.keyed) begin
            y     <= '0;
            state <= S_INNER;
          end else if (x_last) begin
            x     <= '0;
            state <= S_ERD;
          end else begin
            x     <= x + 1'b1;
            state <= S_XRD;
          end
        end
        S_INNER: begin
          if (swap) begin
            cur <= rdata;
          end
          if (y_last) begin
            state <= S_XWB;
          end else begin
            y <= y + 1'b1;
          end
        end
        S_XWB: begin
          if (x_last) begin
            x     <= '0;
            state <= S_ERD;
          end else begin
            x     <= x + 1'b1;
            state <= S_XRD;
          end
        end
        S_ERD: begin
          state <= S_ELD;
        end
        S_ELD: begin
          result       <= '{out_handle: rdata.handle, out_key: rdata.key,
                            out_has_key: rdata.keyed, out_last: x_last};
          result_valid <= 1'b1;
          state        <= S_EOUT;
        end
        S_EOUT: begin
          if (result_ready) begin
            result_valid <= 1'b0;
            if (x_last) begin
              count <= '0;
              state <= S_LOAD;
            end else begin
              x     <= x + 1'b1;
              state <= S_ERD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_load_while_emitting: assert property (@(posedge clk) disable iff (rst)
    item_ready |-> !result_valid)
    else $error("item taken while a result is pending");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= cnt_t'(MAX_ITEMS))
    else $error("entry count beyond store depth");

  a_count_cleared: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_ready && result.out_last) |=> (count == '0) && item_ready)
    else $error("set not closed after final result");

  a_index_in_set: assert property (@(posedge clk) disable iff (rst)
    (state != S_LOAD) |-> (count != '0) && (x <= last_idx))
    else $error("position outside stored set");
`endif

endmodule
